[src/agam_pkg.sv]
// Package for the adaptive-gain audio mixer: item structs, widths and constants.
// No dependencies; used by adaptive_gain_audio_mixer.
`default_nettype none
package agam_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int FIELDS        = 8;
  localparam int CHANNELS_DEF  = 8;
  localparam int SUM_W         = 20;
  localparam int MAG_W         = 19;
  localparam int GAIN_W        = 16;
  localparam int GAIN_FRAC     = 15;
  localparam int RECOVER_SHIFT = 5;
  localparam int ALU_W         = 21;
  localparam int QUO_W         = 15;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'h8000;
  localparam logic [MAG_W-1:0]  POS_LIMIT = 19'h07FFF;
  localparam logic [MAG_W-1:0]  NEG_LIMIT = 19'h08000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
    logic signed [SAMPLE_W-1:0] sample_4;
    logic signed [SAMPLE_W-1:0] sample_5;
    logic signed [SAMPLE_W-1:0] sample_6;
    logic signed [SAMPLE_W-1:0] sample_7;
    logic [FIELDS-1:0]          channel_mask;
    logic                       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       clipped;
  } out_item_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ACC  = 8'b0000_0010,
    ST_MAG  = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_CHK  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_REC  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

endpackage
`default_nettype wire

[src/adaptive_gain_audio_mixer.sv]
// Adaptive-gain audio mixer top level: sequencer around one shared adder,
// one multiplier and a bit-serial divider. Depends on agam_pkg.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (agam_pkg::in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (agam_pkg::out_item_t)
//
// Items pass through the sequencer one at a time; when the result clips, a
// divider finds the new gain, one quotient bit per cycle. Channel summing runs one
// channel a cycle through the shared adder. Reset sets the gain to 1.0 and
// empties the output register. A stalled output holds the sequencer in its
// last state; the next item is taken as soon as the result is registered.
`default_nettype none
module adaptive_gain_audio_mixer #(
  parameter int CHANNELS = agam_pkg::CHANNELS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire agam_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output agam_pkg::out_item_t      out_data_o
);

  localparam int USED = (CHANNELS < agam_pkg::FIELDS) ? CHANNELS : agam_pkg::FIELDS;
  localparam int CH_W = $clog2(agam_pkg::FIELDS);
  localparam int CNT_W = $clog2(agam_pkg::QUO_W);
  localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(USED - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(agam_pkg::QUO_W - 1);
  localparam int PROD_W = agam_pkg::MAG_W + agam_pkg::GAIN_W;

  agam_pkg::state_e state_q, state_d;
  agam_pkg::in_item_t  in_q, in_d;
  agam_pkg::out_item_t out_q, out_d;
  logic                              out_valid_q, out_valid_d;
  logic [agam_pkg::GAIN_W-1:0]       gain_q, gain_d;
  logic signed [agam_pkg::SUM_W-1:0] acc_q, acc_d;
  logic [agam_pkg::MAG_W-1:0]        mag_q, mag_d;
  logic [agam_pkg::MAG_W-1:0]        scaled_q, scaled_d;
  logic [agam_pkg::MAG_W-1:0]        rem_q, rem_d;
  logic [agam_pkg::QUO_W-1:0]        quo_q, quo_d;
  logic [CH_W-1:0]                   ch_q, ch_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic                              neg_q, neg_d;
  logic                              clip_q, clip_d;

  logic signed [agam_pkg::SAMPLE_W-1:0] samples [agam_pkg::FIELDS];
  logic [agam_pkg::ALU_W-1:0]  alu_a, alu_b, alu_y;
  logic                        alu_cin;
  logic [agam_pkg::ALU_W-1:0]  acc_ext, smp_ext;
  logic [agam_pkg::MAG_W:0]    rem2;
  logic [PROD_W-1:0]           prod;
  logic [agam_pkg::MAG_W-1:0]  limit;
  logic [agam_pkg::GAIN_W-1:0] gain_gap, gain_step;
  logic [agam_pkg::SAMPLE_W-1:0] res_mag;
  logic                        q_bit;

  always_comb begin
    samples[0] = in_q.sample_0;
    samples[1] = in_q.sample_1;
    samples[2] = in_q.sample_2;
    samples[3] = in_q.sample_3;
    samples[4] = in_q.sample_4;
    samples[5] = in_q.sample_5;
    samples[6] = in_q.sample_6;
    samples[7] = in_q.sample_7;
  end

  assign acc_ext   = agam_pkg::ALU_W'(acc_q);
  assign smp_ext   = agam_pkg::ALU_W'(samples[ch_q]);
  assign rem2      = {rem_q, 1'b0};
  assign prod      = PROD_W'(mag_q) * PROD_W'(gain_q);
  assign limit     = neg_q ? agam_pkg::NEG_LIMIT : agam_pkg::POS_LIMIT;
  assign gain_gap  = agam_pkg::GAIN_ONE - gain_q;
  assign gain_step = gain_gap >> agam_pkg::RECOVER_SHIFT;
  assign res_mag   = scaled_q[agam_pkg::SAMPLE_W-1:0];
  assign q_bit     = ~alu_y[agam_pkg::ALU_W-1];

  // shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state_q)
      agam_pkg::ST_ACC: begin
        alu_a = acc_ext;
        alu_b = in_q.channel_mask[ch_q] ? smp_ext : '0;
      end
      agam_pkg::ST_MAG: begin
        alu_b   = acc_q[agam_pkg::SUM_W-1] ? ~acc_ext : acc_ext;
        alu_cin = acc_q[agam_pkg::SUM_W-1];
      end
      agam_pkg::ST_DIV: begin
        alu_a   = agam_pkg::ALU_W'(rem2);
        alu_b   = ~agam_pkg::ALU_W'(scaled_q);
        alu_cin = 1'b1;
      end
      agam_pkg::ST_REC: begin
        alu_a = agam_pkg::ALU_W'(gain_q);
        alu_b = agam_pkg::ALU_W'(gain_step);
      end
      default: begin
      end
    endcase
    alu_y = alu_a + alu_b + agam_pkg::ALU_W'(alu_cin);
  end

  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    gain_d      = gain_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    scaled_d    = scaled_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    clip_d      = clip_q;
    unique case (state_q)
      agam_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          acc_d   = '0;
          ch_d    = '0;
          state_d = agam_pkg::ST_ACC;
          if (in_data_i.frame_start) gain_d = agam_pkg::GAIN_ONE;
        end
      end
      agam_pkg::ST_ACC: begin
        acc_d = alu_y[agam_pkg::SUM_W-1:0];
        ch_d  = ch_q + 1'b1;
        if (ch_q == CH_LAST) state_d = agam_pkg::ST_MAG;
      end
      agam_pkg::ST_MAG: begin
        neg_d   = acc_q[agam_pkg::SUM_W-1];
        mag_d   = alu_y[agam_pkg::MAG_W-1:0];
        state_d = agam_pkg::ST_MUL;
      end
      agam_pkg::ST_MUL: begin
        scaled_d = prod[agam_pkg::GAIN_FRAC +: agam_pkg::MAG_W];
        state_d  = agam_pkg::ST_CHK;
      end
      agam_pkg::ST_CHK: begin
        clip_d = scaled_q > limit;
        rem_d  = limit;
        quo_d  = '0;
        cnt_d  = '0;
        state_d = (scaled_q > limit) ? agam_pkg::ST_DIV : agam_pkg::ST_REC;
      end
      agam_pkg::ST_DIV: begin
        rem_d = q_bit ? alu_y[agam_pkg::MAG_W-1:0] : rem2[agam_pkg::MAG_W-1:0];
        quo_d = {quo_q[agam_pkg::QUO_W-2:0], q_bit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          gain_d   = agam_pkg::GAIN_W'(quo_d);
          scaled_d = limit;
          state_d  = agam_pkg::ST_REC;
        end
      end
      agam_pkg::ST_REC: begin
        if (!gain_q[agam_pkg::GAIN_W-1]) gain_d = alu_y[agam_pkg::GAIN_W-1:0];
        state_d = agam_pkg::ST_OUT;
      end
      agam_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.mixed_sample = neg_q ? -res_mag : res_mag;
          out_d.clipped      = clip_q;
          out_valid_d        = 1'b1;
          state_d            = agam_pkg::ST_IDLE;
        end
      end
      default: state_d = agam_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= agam_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      gain_q      <= agam_pkg::GAIN_ONE;
      ch_q        <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      gain_q      <= gain_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    out_q    <= out_d;
    acc_q    <= acc_d;
    mag_q    <= mag_d;
    scaled_q <= scaled_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    neg_q    <= neg_d;
    clip_q   <= clip_d;
  end

  assign in_stall_o  = (state_q != agam_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
